// ===== rtl/core/dpsc_pkg.sv =====
// Shared types, register indexes, codes and segment table of the pedal sensor check.
`default_nettype none

package dpsc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_FIRST_REST   = 3'd0;
    localparam logic [2:0] REG_FIRST_FULL   = 3'd1;
    localparam logic [2:0] REG_SECOND_REST  = 3'd2;
    localparam logic [2:0] REG_SECOND_FULL  = 3'd3;
    localparam logic [2:0] REG_WINDOW       = 3'd4;
    localparam logic [2:0] REG_DIVERGENCE   = 3'd5;
    localparam logic [2:0] REG_REFRESH      = 3'd6;

    // Register reset values
    localparam logic [9:0] RST_FIRST_REST  = 10'd833;
    localparam logic [9:0] RST_FIRST_FULL  = 10'd190;
    localparam logic [9:0] RST_SECOND_REST = 10'd413;
    localparam logic [9:0] RST_SECOND_FULL = 10'd87;
    localparam logic [9:0] RST_WINDOW      = 10'd10;
    localparam logic [6:0] RST_DIVERGENCE  = 7'd10;
    localparam logic [7:0] RST_REFRESH     = 8'd5;

    // Digit codes for the Err pattern
    localparam logic [3:0] CODE_E = 4'd10;
    localparam logic [3:0] CODE_R = 4'd11;

    // Fault causes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_WINDOW  = 2'd1;
    localparam logic [1:0] CAUSE_DIVERGE = 2'd2;

    // Input commands
    localparam logic CMD_READING = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [6:0] PERCENT_MAX = 7'd100;

    typedef struct packed {
        logic [9:0] first_rest_value;
        logic [9:0] first_full_value;
        logic [9:0] second_rest_value;
        logic [9:0] second_full_value;
        logic [9:0] window_margin;
        logic [6:0] divergence_limit;
        logic [7:0] refresh_period;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [9:0] first_reading;
        logic [9:0] second_reading;
    } in_item_t;

    typedef struct packed {
        logic [7:0] segment_drive;
        logic [2:0] digit_enable;
        logic       fault;
        logic [1:0] fault_cause;
        logic [6:0] pedal_level;
    } out_item_t;

    // Classified item passed from front to back; differences are 11-bit two's complement
    typedef struct packed {
        logic        is_tick;
        logic        window_fault;
        logic [10:0] diff1;
        logic [10:0] span1;
        logic [10:0] diff2;
        logic [10:0] span2;
    } cmd_item_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] pat;
        begin
            unique case (code)
                4'd0:    pat = 8'h40;
                4'd1:    pat = 8'h79;
                4'd2:    pat = 8'h24;
                4'd3:    pat = 8'h30;
                4'd4:    pat = 8'h19;
                4'd5:    pat = 8'h12;
                4'd6:    pat = 8'h02;
                4'd7:    pat = 8'h78;
                4'd8:    pat = 8'h80;
                4'd9:    pat = 8'h18;
                4'd10:   pat = 8'h06;
                4'd11:   pat = 8'h2F;
                default: pat = 8'h00;
            endcase
            return pat;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dual_pedal_sensor_check_display_top.sv =====
// Top level of the dual pedal sensor plausibility check with multiplexed display.
`default_nettype none

// Each item is either a pair of raw 10-bit pedal readings (command 0) or a one
// millisecond tick (command 1), and every item yields exactly one result item
// holding the latched segment pattern, digit enable, fault flag, fault cause
// and last valid pedal level. Items enter through a two-entry queue (push/full)
// and results leave through another two-entry queue (empty/pop), so the source
// and the sink stall independently. The front end runs the window check and
// queues the classified item; the back end carries it out one at a time. A tick
// or a reading pair that fails the window check goes straight to the result push.
// A reading pair that passes maps both sensors to a percent through one shared
// restoring divider (operand setup, saturation check, 7 quotient steps per
// sensor), then runs the divergence check and, if that passes, the decimal
// split, then the result push. After reset the display holds Err with no cause,
// digit enable reads 0 until the first refresh, and the first refresh shows
// digit 1. Configuration registers are written through cfg_write/cfg_index/
// cfg_data and must only change while the block is idle; index 7 is ignored.

module dual_pedal_sensor_check_display_top
    import dpsc_pkg::*;
#(
    parameter int DIGIT_COUNT = 3
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    // Item side
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  command_item,
    // Result side
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      display_item,
    // Configuration write port
    input  wire logic       cfg_write,
    input  wire logic [2:0] cfg_index,
    input  wire logic [9:0] cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    cmd_item_t cmd;
    logic      cmd_empty, cmd_pop;
    logic      res_full, res_push;
    out_item_t res;

    // Register file: write in place, ignore unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIRST_REST:  cfg_next.first_rest_value  = cfg_data;
                REG_FIRST_FULL:  cfg_next.first_full_value  = cfg_data;
                REG_SECOND_REST: cfg_next.second_rest_value = cfg_data;
                REG_SECOND_FULL: cfg_next.second_full_value = cfg_data;
                REG_WINDOW:      cfg_next.window_margin     = cfg_data;
                REG_DIVERGENCE:  cfg_next.divergence_limit  = cfg_data[6:0];
                REG_REFRESH:     cfg_next.refresh_period    = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_rest_value  <= RST_FIRST_REST;
            cfg_reg.first_full_value  <= RST_FIRST_FULL;
            cfg_reg.second_rest_value <= RST_SECOND_REST;
            cfg_reg.second_full_value <= RST_SECOND_FULL;
            cfg_reg.window_margin     <= RST_WINDOW;
            cfg_reg.divergence_limit  <= RST_DIVERGENCE;
            cfg_reg.refresh_period    <= RST_REFRESH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: window check and classification, queued toward the back end
    dpsc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .push  (push),
        .item  (command_item),
        .full  (full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .cmd   (cmd)
    );

    // Back end: ticks, percent mapping, plausibility and display state
    dpsc_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue: hold finished items until the sink pops them
    dpsc_queue #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (display_item),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dpsc_queue.sv =====
// Small register FIFO with push/full and pop/empty sides.
`default_nettype none

module dpsc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dpsc_front.sv =====
// Front end: accept items, run the window check and queue classified work for the back end.
`default_nettype none

module dpsc_front
    import dpsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      push,
    input  wire in_item_t  item,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output cmd_item_t      cmd
);

    cmd_item_t cls;
    logic      out1, out2;

    // Window: min(rest,full)-margin .. max(rest,full)+margin, no wrap
    function automatic logic outside_window(
        input logic [9:0] r,
        input logic [9:0] rest,
        input logic [9:0] full_v,
        input logic [9:0] margin
    );
        logic [9:0]         lo_base, hi_base;
        logic signed [11:0] lo;
        logic [10:0]        hi;
        begin
            lo_base = (rest < full_v) ? rest : full_v;
            hi_base = (rest > full_v) ? rest : full_v;
            lo = $signed({2'b00, lo_base}) - $signed({2'b00, margin});
            hi = {1'b0, hi_base} + {1'b0, margin};
            return ($signed({2'b00, r}) < lo) || ({1'b0, r} > hi);
        end
    endfunction

    always_comb
    begin
        out1 = outside_window(item.first_reading, cfg.first_rest_value,
                              cfg.first_full_value, cfg.window_margin);
        out2 = outside_window(item.second_reading, cfg.second_rest_value,
                              cfg.second_full_value, cfg.window_margin);
        cls.is_tick      = (item.command == CMD_TICK);
        cls.window_fault = out1 || out2;
        cls.diff1 = {1'b0, item.first_reading}    - {1'b0, cfg.first_rest_value};
        cls.span1 = {1'b0, cfg.first_full_value}  - {1'b0, cfg.first_rest_value};
        cls.diff2 = {1'b0, item.second_reading}   - {1'b0, cfg.second_rest_value};
        cls.span2 = {1'b0, cfg.second_full_value} - {1'b0, cfg.second_rest_value};
    end

    dpsc_queue #(
        .WIDTH ($bits(cmd_item_t)),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (pop),
        .rdata (cmd),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dpsc_back.sv =====
// Back end: tick handling, percent mapping through a shared divider, and display state.
`default_nettype none

module dpsc_back
    import dpsc_pkg::*;
#(
    parameter int DIGIT_COUNT = 3
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      cmd_empty,
    input  wire cmd_item_t cmd,
    output logic           cmd_pop,
    input  wire logic      res_full,
    output logic           res_push,
    output out_item_t      res
);

    localparam int AD_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_DIGITS = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic            sel_reg, sel_next;
    logic [2:0]      cnt_reg, cnt_next;
    cmd_item_t       cmd_reg, cmd_next;
    logic [16:0]     rem_reg, rem_next;
    logic [16:0]     dsh_reg, dsh_next;
    logic [9:0]      den_reg, den_next;
    logic [6:0]      q_reg, q_next;
    logic            zero_reg, zero_next;
    logic            sat_reg, sat_next;
    logic [6:0]      p0_reg, p0_next;
    logic [6:0]      p1_reg, p1_next;
    logic [6:0]      avg_reg, avg_next;

    logic [3:0]      codes_reg [3];
    logic [3:0]      codes_next [3];
    logic [AD_W-1:0] ad_reg, ad_next;
    logic [7:0]      elapsed_reg, elapsed_next;
    logic [7:0]      seg_reg, seg_next;
    logic [2:0]      en_reg, en_next;
    logic [1:0]      cause_reg, cause_next;
    logic [6:0]      level_reg, level_next;
    logic            fault_reg, fault_next;

    // Combinational helpers
    logic [AD_W-1:0] ad_inc;
    logic [2:0]      digit_idx;
    logic [3:0]      digit_code;
    logic [10:0]     op_diff, op_span, neg_diff, neg_span;
    logic [9:0]      mag_diff;
    logic [16:0]     num;
    logic            step_take;
    logic [6:0]      q_final, p_final;
    logic [6:0]      pdiff;
    logic [7:0]      psum;
    logic [6:0]      low_part;
    logic [14:0]     tens_prod;
    logic [3:0]      tens, units;
    logic [6:0]      tens_x10;

    always_comb
    begin
        // Next digit position and its pattern
        ad_inc     = (ad_reg == AD_W'(DIGIT_COUNT - 1)) ? '0 : ad_reg + 1'b1;
        digit_idx  = 3'(ad_inc);
        digit_code = (digit_idx < 3'd3) ? codes_reg[digit_idx[1:0]] : 4'd0;

        // Divider operands for the selected sensor
        op_diff  = sel_reg ? cmd_reg.diff2 : cmd_reg.diff1;
        op_span  = sel_reg ? cmd_reg.span2 : cmd_reg.span1;
        neg_diff = ~op_diff + 11'd1;
        neg_span = ~op_span + 11'd1;
        mag_diff = op_diff[10] ? neg_diff[9:0] : op_diff[9:0];
        num      = 17'({mag_diff, 6'b0}) + 17'({mag_diff, 5'b0}) + 17'({mag_diff, 2'b0});

        // One restoring step
        step_take = (rem_reg >= dsh_reg);
        q_final   = {q_reg[5:0], step_take};
        if (zero_reg)
        begin
            p_final = 7'd0;
        end
        else if (sat_reg || (q_final > PERCENT_MAX))
        begin
            p_final = PERCENT_MAX;
        end
        else
        begin
            p_final = q_final;
        end

        // Plausibility
        pdiff = (p0_reg > p1_reg) ? p0_reg - p1_reg : p1_reg - p0_reg;
        psum  = {1'b0, p0_reg} + {1'b0, p1_reg};

        // Decimal split of the average (at most 100)
        low_part  = (avg_reg >= PERCENT_MAX) ? avg_reg - PERCENT_MAX : avg_reg;
        tens_prod = 15'(low_part) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = 7'({tens, 3'b0}) + 7'({tens, 1'b0});
        units     = 4'(low_part - tens_x10);
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        zero_next    = zero_reg;
        sat_next     = sat_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        avg_next     = avg_reg;
        codes_next   = codes_reg;
        ad_next      = ad_reg;
        elapsed_next = elapsed_reg;
        seg_next     = seg_reg;
        en_next      = en_reg;
        cause_next   = cause_reg;
        level_next   = level_reg;
        fault_next   = fault_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take work only with a free result slot, so the result push never stalls
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    sel_next = 1'b0;
                    if (cmd.is_tick)
                    begin
                        if (elapsed_reg >= cfg.refresh_period)
                        begin
                            elapsed_next = 8'd0;
                            ad_next      = ad_inc;
                            en_next      = 3'b001 << digit_idx;
                            seg_next     = seg_pattern(digit_code);
                        end
                        else
                        begin
                            elapsed_next = elapsed_reg + 8'd1;
                        end
                        state_next = S_EMIT;
                    end
                    else if (cmd.window_fault)
                    begin
                        codes_next = '{CODE_E, CODE_R, CODE_R};
                        fault_next = 1'b1;
                        cause_next = CAUSE_WINDOW;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                // Scale numerator by 100; zero result on equal calibration, zero difference or opposite signs
                rem_next   = num;
                den_next   = op_span[10] ? neg_span[9:0] : op_span[9:0];
                zero_next  = (op_span == 11'd0) || (op_diff == 11'd0)
                             || (op_diff[10] != op_span[10]);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // Quotient of 128 or more clamps straight to 100
                sat_next   = (rem_reg >= {den_reg, 7'b0});
                dsh_next   = {1'b0, den_reg, 6'b0};
                q_next     = 7'd0;
                cnt_next   = 3'd6;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_take)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next = {1'b0, dsh_reg[16:1]};
                q_next   = q_final;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    if (sel_reg)
                    begin
                        p1_next    = p_final;
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        p0_next    = p_final;
                        sel_next   = 1'b1;
                        state_next = S_PREP;
                    end
                end
            end
            S_EVAL:
            begin
                if (pdiff > cfg.divergence_limit)
                begin
                    codes_next = '{CODE_E, CODE_R, CODE_R};
                    fault_next = 1'b1;
                    cause_next = CAUSE_DIVERGE;
                    state_next = S_EMIT;
                end
                else
                begin
                    avg_next   = psum[7:1];
                    state_next = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                codes_next = '{(avg_reg >= PERCENT_MAX) ? 4'd1 : 4'd0, tens, units};
                fault_next = 1'b0;
                cause_next = CAUSE_NONE;
                level_next = avg_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.segment_drive = seg_reg;
    assign res.digit_enable  = en_reg;
    assign res.fault         = fault_reg;
    assign res.fault_cause   = cause_reg;
    assign res.pedal_level   = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_reg     <= 1'b0;
            cnt_reg     <= 3'd0;
            codes_reg   <= '{CODE_E, CODE_R, CODE_R};
            ad_reg      <= '0;
            elapsed_reg <= 8'd0;
            seg_reg     <= 8'd0;
            en_reg      <= 3'd0;
            cause_reg   <= CAUSE_NONE;
            level_reg   <= 7'd0;
            fault_reg   <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            cnt_reg     <= cnt_next;
            codes_reg   <= codes_next;
            ad_reg      <= ad_next;
            elapsed_reg <= elapsed_next;
            seg_reg     <= seg_next;
            en_reg      <= en_next;
            cause_reg   <= cause_next;
            level_reg   <= level_next;
            fault_reg   <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        avg_reg  <= avg_next;
    end

endmodule

`default_nettype wire
